/* rtl/core/char_lcd_write_sequencer_top_defines.svh */
// Assertion macros used by the back end of the character LCD write sequencer RTL.
`ifndef CHAR_LCD_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_WRITE_SEQUENCER_TOP_DEFINES_SVH

// Implication or plain property, checked out of reset.
`define LCDWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define LCDWS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/lcdws_pkg.sv */
// Types, constants and helper functions of the character LCD write sequencer.
package lcdws_pkg;

    localparam int RESULT_CAP     = 42;
    localparam int LINE_CHARS_DEF = 20;
    localparam int CNT_W          = $clog2(RESULT_CAP);
    localparam int NUM_W          = 14;
    localparam int JOBQ_DEPTH     = 2;

    localparam logic [7:0]  SET_ADDR_CMD = 8'h80;
    localparam logic [7:0]  ASCII_ZERO   = 8'h30;
    localparam logic [7:0]  ASCII_SPACE  = 8'h20;
    localparam logic [15:0] NUM_LIMIT    = 16'd10000;

    localparam logic [7:0] ROW1_OFF_RST = 8'hC0;
    localparam logic [7:0] ROW2_OFF_RST = 8'h94;
    localparam logic [7:0] ROW3_OFF_RST = 8'hD4;

    typedef enum logic [2:0] {
        REQ_CMD   = 3'd0,
        REQ_CHAR  = 3'd1,
        REQ_NUM   = 3'd2,
        REQ_MOVE  = 3'd3,
        REQ_CLEAR = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        CFG_FOUR_BIT = 2'd0,
        CFG_ROW1     = 2'd1,
        CFG_ROW2     = 2'd2,
        CFG_ROW3     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,
        K_NUM   = 2'd1,
        K_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_BYTE  = 2'd1,
        S_DIGIT = 2'd2,
        S_SPACE = 2'd3
    } t_state;

    typedef struct packed {
        logic       four_bit;
        logic [7:0] row1;
        logic [7:0] row2;
        logic [7:0] row3;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic             rs;
        logic [7:0]       data;
        logic [NUM_W-1:0] num;
        logic [1:0]       place;
    } t_job;

    typedef struct packed {
        logic [3:0]       d;
        logic [NUM_W-1:0] rem;
    } t_digit;

    // Upper bound of the remaining number while sitting at a decimal place.
    function automatic logic [NUM_W-1:0] place_bound(input logic [1:0] p);
        logic [NUM_W-1:0] b;
        case (p)
            2'd0:    b = NUM_W'(10);
            2'd1:    b = NUM_W'(100);
            2'd2:    b = NUM_W'(1000);
            default: b = NUM_W'(10000);
        endcase
        return b;
    endfunction

    // One decimal digit: parallel compares against constant multiples.
    function automatic t_digit digit_step(input logic [NUM_W-1:0] num,
                                          input logic [1:0] p);
        t_digit r;
        r.d   = 4'd0;
        r.rem = num;
        case (p)
            2'd0: begin
                r.d   = num[3:0];
                r.rem = '0;
            end
            2'd1: begin
                for (int k = 1; k < 10; k++) begin
                    if (num >= NUM_W'(k * 10)) begin
                        r.d   = 4'(k);
                        r.rem = num - NUM_W'(k * 10);
                    end
                end
            end
            2'd2: begin
                for (int k = 1; k < 10; k++) begin
                    if (num >= NUM_W'(k * 100)) begin
                        r.d   = 4'(k);
                        r.rem = num - NUM_W'(k * 100);
                    end
                end
            end
            default: begin
                for (int k = 1; k < 10; k++) begin
                    if (num >= NUM_W'(k * 1000)) begin
                        r.d   = 4'(k);
                        r.rem = num - NUM_W'(k * 1000);
                    end
                end
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/lcdws_front.sv */
// Front end: classifies a request into a job descriptor for the back end.
module lcdws_front
    import lcdws_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_row,
    output logic        o_keep,
    output t_job        o_job
);

    logic [7:0] row_off;
    logic [7:0] move_addr;
    logic [7:0] clr_addr;

    always_comb begin
        unique case (i_row)
            8'd1:    row_off = i_cfg.row1;
            8'd2:    row_off = i_cfg.row2;
            8'd3:    row_off = i_cfg.row3;
            default: row_off = 8'h00;
        endcase
    end

    assign move_addr = SET_ADDR_CMD | (i_column + row_off);
    assign clr_addr  = SET_ADDR_CMD | row_off;

    always_comb begin
        o_keep       = 1'b0;
        o_job.kind   = K_BYTE;
        o_job.rs     = 1'b0;
        o_job.data   = i_value[7:0];
        o_job.num    = i_value[NUM_W-1:0];
        o_job.place  = 2'd3;
        unique case (t_req'(i_req_type))
            REQ_CMD: begin
                o_keep = 1'b1;
            end
            REQ_CHAR: begin
                o_keep   = 1'b1;
                o_job.rs = 1'b1;
            end
            REQ_NUM: begin
                o_keep     = (i_value < NUM_LIMIT);
                o_job.kind = K_NUM;
                o_job.rs   = 1'b1;
                if (i_value < 16'd100) begin
                    o_job.place = 2'd1;   // also covers the leading zero
                end else if (i_value < 16'd1000) begin
                    o_job.place = 2'd2;
                end
            end
            REQ_MOVE: begin
                o_keep     = 1'b1;
                o_job.data = move_addr;
            end
            REQ_CLEAR: begin
                o_keep     = 1'b1;
                o_job.kind = K_CLEAR;
                o_job.data = clr_addr;
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/lcdws_jobq.sv */
// Short job queue between the front and back ends.
module lcdws_jobq
    import lcdws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int CNT_QW = $clog2(JOBQ_DEPTH + 1);

    t_job              r_mem [JOBQ_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_QW-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_QW'(JOBQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_QW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* rtl/core/lcdws_back.sv */
// Back end: walks a job byte by byte and emits one bus strobe per beat.
`include "char_lcd_write_sequencer_top_defines.svh"

module lcdws_back
    import lcdws_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_job       i_q_job,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic       o_reg_select,
    output logic [7:0] o_bus_data,
    output logic       o_last
);

    localparam int SPC_W = $clog2(LINE_CHARS + 1);

    t_state           r_state;
    t_state           n_state;
    t_kind            r_kind;
    t_kind            n_kind;
    logic             r_rs;
    logic             n_rs;
    logic [7:0]       r_byte;
    logic [7:0]       n_byte;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] n_num;
    logic [1:0]       r_place;
    logic [1:0]       n_place;
    logic [SPC_W-1:0] r_spaces;
    logic [SPC_W-1:0] n_spaces;
    logic             r_lo;
    logic             n_lo;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic       r_out_v;
    logic       r_out_rs;
    logic [7:0] r_out_data;
    logic       r_out_last;

    t_digit     dig;
    logic [7:0] cur_byte;
    logic       cur_rs;
    logic [7:0] strobe;
    logic       emit;
    logic       load;
    logic       byte_done;
    logic       job_end;
    logic       cap_hit;
    logic       strobe_last;

    assign emit    = (r_state != S_IDLE) && (!r_out_v || i_pop);
    assign load    = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop = load;
    assign dig     = digit_step(r_num, r_place);

    always_comb begin
        cur_byte = r_byte;
        cur_rs   = r_rs;
        job_end  = 1'b0;
        unique case (r_state)
            S_BYTE: begin
                job_end = (r_kind != K_CLEAR);
            end
            S_DIGIT: begin
                cur_byte = ASCII_ZERO + {4'h0, dig.d};
                cur_rs   = 1'b1;
                job_end  = (r_place == 2'd0);
            end
            S_SPACE: begin
                cur_byte = ASCII_SPACE;
                cur_rs   = 1'b1;
                job_end  = (r_spaces == SPC_W'(1));
            end
            default: begin
                job_end = 1'b0;
            end
        endcase
    end

    // high nibble first in four-bit mode
    assign strobe      = !i_cfg.four_bit ? cur_byte :
                         (r_lo ? {4'h0, cur_byte[3:0]} : {4'h0, cur_byte[7:4]});
    assign byte_done   = !i_cfg.four_bit || r_lo;
    assign cap_hit     = (r_cnt == CNT_W'(RESULT_CAP - 1));
    assign strobe_last = (byte_done && job_end) || cap_hit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_job.kind == K_NUM) ? S_DIGIT : S_BYTE;
                end
            end
            S_BYTE: begin
                if (emit && strobe_last) begin
                    n_state = S_IDLE;
                end else if (emit && byte_done) begin
                    n_state = S_SPACE;
                end
            end
            S_DIGIT, S_SPACE: begin
                if (emit && strobe_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // job datapath
    always_comb begin
        n_kind   = r_kind;
        n_rs     = r_rs;
        n_byte   = r_byte;
        n_num    = r_num;
        n_place  = r_place;
        n_spaces = r_spaces;
        n_lo     = r_lo;
        n_cnt    = r_cnt;
        if (load) begin
            n_kind  = i_q_job.kind;
            n_rs    = i_q_job.rs;
            n_byte  = i_q_job.data;
            n_num   = i_q_job.num;
            n_place = i_q_job.place;
        end else if (emit) begin
            if (strobe_last) begin
                n_lo  = 1'b0;
                n_cnt = '0;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
                n_lo  = i_cfg.four_bit && !r_lo;
                if (byte_done) begin
                    unique case (r_state)
                        S_BYTE: begin
                            n_spaces = SPC_W'(LINE_CHARS);
                        end
                        S_DIGIT: begin
                            n_num   = dig.rem;
                            n_place = r_place - 2'd1;
                        end
                        S_SPACE: begin
                            n_spaces = r_spaces - SPC_W'(1);
                        end
                        default: begin
                            n_spaces = r_spaces;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lo    <= 1'b0;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lo    <= n_lo;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_rs     <= n_rs;
        r_byte   <= n_byte;
        r_num    <= n_num;
        r_place  <= n_place;
        r_spaces <= n_spaces;
        if (emit) begin
            r_out_rs   <= cur_rs;
            r_out_data <= strobe;
            r_out_last <= strobe_last;
        end
    end

    assign o_empty      = !r_out_v;
    assign o_reg_select = r_out_rs;
    assign o_bus_data   = r_out_data;
    assign o_last       = r_out_last;

    `LCDWS_ASSERT(a_idle_clean, (r_state == S_IDLE) |-> (r_cnt == '0 && !r_lo), "idle with stale counters")
    `LCDWS_NEVER(a_cnt_cap, r_cnt > CNT_W'(RESULT_CAP - 1), "strobe count past cap")
    `LCDWS_ASSERT(a_digit_range, (r_state == S_DIGIT) |-> (r_num < place_bound(r_place)), "digit remainder out of range")
    `LCDWS_ASSERT(a_load_idle, o_q_pop |-> (r_state == S_IDLE && i_q_valid), "job taken while busy")

endmodule

/* rtl/core/char_lcd_write_sequencer_top.sv */
// Top level of the character LCD write sequencer: config registers, front, queue, back.
//
// Each accepted request turns into a train of bus strobe beats, one beat per
// cycle at best: a command or character gives one byte, a number below 10000
// gives two to four ASCII digits (a lone digit gets a leading zero), a cursor
// move gives the set-address command 0x80 | (column + row offset), and a line
// clear gives that command for column 0 followed by LINE_CHARS spaces. In
// four-bit mode every byte is two beats, high nibble first in bus_data[3:0].
// At most 42 beats leave per request; last marks the final one. A request
// leaves the job queue only while the back end is idle, and its beats then
// follow; the back-end sequencer with its single output register sets the
// pace.
// The front end classifies and queues up to two further requests while the
// back end works, so push keeps going until the job queue fills. Numbers of
// 10000 or more and unknown request types are accepted and give no beats.
// Config registers are written directly through i_cfg_we / i_cfg_idx /
// i_cfg_data and must only change while the block is idle.
module char_lcd_write_sequencer_top
    import lcdws_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_row,
    // strobe side
    output logic        empty,
    input  logic        pop,
    output logic        o_reg_select,
    output logic [7:0]  o_bus_data,
    output logic        o_last
);

    t_cfg r_cfg;
    logic front_keep;
    t_job front_job;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job q_job;

    // config registers, reset to the standard 20x4 row layout
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.four_bit <= 1'b1;
            r_cfg.row1     <= ROW1_OFF_RST;
            r_cfg.row2     <= ROW2_OFF_RST;
            r_cfg.row3     <= ROW3_OFF_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FOUR_BIT: r_cfg.four_bit <= i_cfg_data[0];
                CFG_ROW1:     r_cfg.row1     <= i_cfg_data;
                CFG_ROW2:     r_cfg.row2     <= i_cfg_data;
                CFG_ROW3:     r_cfg.row3     <= i_cfg_data;
            endcase
        end
    end

    lcdws_front u_front (
        .i_cfg      (r_cfg),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .i_column   (i_column),
        .i_row      (i_row),
        .o_keep     (front_keep),
        .o_job      (front_job)
    );

    // requests with no beats are accepted but never queued
    assign q_push = push && !full && front_keep;

    lcdws_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    lcdws_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_job      (q_job),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_reg_select (o_reg_select),
        .o_bus_data   (o_bus_data),
        .o_last       (o_last)
    );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the character LCD write sequencer: random requests, strobe beat checks.
module tb_top
    import lcdws_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 4;
    localparam int RST_CYCLES     = 10;
    localparam int LINE_CHARS     = LINE_CHARS_DEF;
    // Idle wait before a register write: room for two queued requests plus
    // one in the back end, with plenty of margin.
    localparam int SETTLE_CYCLES  = 200;
    // Longest correct stretch without a beat on either side is the settle
    // wait plus a sender gap plus a receiver stall.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 50;
    localparam int FORCED_DRAIN   = 60;

    // Request types the block ignores.
    localparam logic [2:0] REQ_BAD_LO = 3'd5;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;

    typedef struct {
        logic [2:0]  req_type;
        logic [15:0] value;
        logic [7:0]  column;
        logic [7:0]  row;
    } t_lcd_req;

    typedef struct {
        logic       rs;
        logic [7:0] data;
        logic       last;
    } t_lcd_strobe;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_SPARSE,
        POP_STALL
    } t_pop_mode;

    // DUT inputs, all known from time zero.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_idx    = CFG_FOUR_BIT;
    logic [7:0]  i_cfg_data   = 8'h00;
    logic        push         = 1'b0;
    logic [2:0]  i_req_type   = REQ_CMD;
    logic [15:0] i_value      = 16'h0000;
    logic [7:0]  i_column     = 8'h00;
    logic [7:0]  i_row        = 8'h00;
    logic        pop          = 1'b0;

    // DUT outputs.
    logic        full;
    logic        empty;
    logic        o_reg_select;
    logic [7:0]  o_bus_data;
    logic        o_last;

    // Shadow of the config registers, as the block should hold them.
    logic        cfg_four_bit = 1'b1;
    logic [7:0]  cfg_row1     = ROW1_OFF_RST;
    logic [7:0]  cfg_row2     = ROW2_OFF_RST;
    logic [7:0]  cfg_row3     = ROW3_OFF_RST;

    t_lcd_req    item_q[$];     // requests waiting for the driver
    t_lcd_strobe strobe_q[$];   // strobe beats still owed by the block
    t_lcd_strobe req_beats[$];  // scratch: beats of the request being predicted
    t_lcd_req    cur_req;

    int          fail_cnt     = 0;
    int          sent_cnt     = 0;
    int          stuck_cycles = 0;
    int          burst_left   = 8;
    int          gap_left     = 0;
    bit          drain_hold   = 1'b0;
    t_pop_mode   pop_mode     = POP_ALWAYS;
    int          pop_left     = 0;

    char_lcd_write_sequencer_top #(
        .LINE_CHARS (LINE_CHARS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .i_column     (i_column),
        .i_row        (i_row),
        .empty        (empty),
        .pop          (pop),
        .o_reg_select (o_reg_select),
        .o_bus_data   (o_bus_data),
        .o_last       (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Strobe predictor
    // ------------------------------------------------------------------

    // One strobe; anything past the per-request cap is dropped.
    function automatic void add_strobe(logic rs, logic [7:0] d);
        t_lcd_strobe s;
        s.rs   = rs;
        s.data = d;
        s.last = 1'b0;
        if (req_beats.size() < RESULT_CAP)
            req_beats.push_back(s);
    endfunction

    // A byte is one strobe in 8-bit mode, two nibble strobes (high first)
    // in 4-bit mode with the nibble in the low half of the bus.
    function automatic void emit_byte(logic rs, logic [7:0] b);
        if (cfg_four_bit) begin
            add_strobe(rs, {4'h0, b[7:4]});
            add_strobe(rs, {4'h0, b[3:0]});
        end else begin
            add_strobe(rs, b);
        end
    endfunction

    // Set-DDRAM-address command; rows past 3 have no offset, sum wraps at 256.
    function automatic void emit_cursor(logic [7:0] column, logic [7:0] row);
        logic [7:0] off;
        logic [7:0] addr;
        case (row)
            8'd1:    off = cfg_row1;
            8'd2:    off = cfg_row2;
            8'd3:    off = cfg_row3;
            default: off = 8'h00;
        endcase
        addr = column + off;
        emit_byte(1'b0, SET_ADDR_CMD | addr);
    endfunction

    // Decimal digits; a single digit gets a leading zero, 10000 and up is silent.
    function automatic void emit_number(logic [15:0] n);
        int unsigned v;
        logic [7:0]  digits[$];
        v = n;
        if (n >= NUM_LIMIT)
            return;
        if (v < 10) begin
            digits.push_back(ASCII_ZERO);
            digits.push_back(ASCII_ZERO + 8'(v));
        end else begin
            while (v != 0) begin
                digits.push_front(ASCII_ZERO + 8'(v % 10));
                v = v / 10;
            end
        end
        foreach (digits[i])
            emit_byte(1'b1, digits[i]);
    endfunction

    // Expected beats of one accepted request, appended to strobe_q.
    function automatic void predict_strobes(t_lcd_req r);
        req_beats.delete();
        case (r.req_type)
            REQ_CMD:   emit_byte(1'b0, r.value[7:0]);
            REQ_CHAR:  emit_byte(1'b1, r.value[7:0]);
            REQ_NUM:   emit_number(r.value);
            REQ_MOVE:  emit_cursor(r.column, r.row);
            REQ_CLEAR: begin
                emit_cursor(8'h00, r.row);
                repeat (LINE_CHARS) emit_byte(1'b1, ASCII_SPACE);
            end
            default: ;
        endcase
        if (req_beats.size() != 0)
            req_beats[req_beats.size() - 1].last = 1'b1;
        foreach (req_beats[i])
            strobe_q.push_back(req_beats[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_lcd_req mk_req(logic [2:0] t, logic [15:0] v,
                                        logic [7:0] c, logic [7:0] r);
        t_lcd_req q;
        q.req_type = t;
        q.value    = v;
        q.column   = c;
        q.row      = r;
        return q;
    endfunction

    // Weighted mix; line clears are long, so they are rarer. Numbers are
    // spread over every digit count, with an occasional oversized one.
    function automatic t_lcd_req rand_req();
        t_lcd_req q;
        int       pick;
        int       span;
        q.value  = 16'($urandom);
        q.column = 8'($urandom);
        q.row    = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        pick     = $urandom_range(0, 99);
        if (pick < 18)
            q.req_type = REQ_CMD;
        else if (pick < 36)
            q.req_type = REQ_CHAR;
        else if (pick < 62)
            q.req_type = REQ_NUM;
        else if (pick < 84)
            q.req_type = REQ_MOVE;
        else if (pick < 94)
            q.req_type = REQ_CLEAR;
        else
            q.req_type = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        if (q.req_type == REQ_NUM) begin
            span = $urandom_range(0, 9);
            if (span < 2)
                q.value = 16'($urandom_range(0, 9));
            else if (span < 4)
                q.value = 16'($urandom_range(10, 99));
            else if (span < 6)
                q.value = 16'($urandom_range(100, 999));
            else if (span < 9)
                q.value = 16'($urandom_range(1000, 9999));
        end
        return q;
    endfunction

    // One register write per edge; the shadow follows immediately since
    // nothing is in flight while config changes.
    task automatic write_reg(t_cfg_idx idx, logic [7:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        case (idx)
            CFG_FOUR_BIT: cfg_four_bit = d[0];
            CFG_ROW1:     cfg_row1     = d;
            CFG_ROW2:     cfg_row2     = d;
            CFG_ROW3:     cfg_row3     = d;
            default: ;
        endcase
    endtask

    task automatic apply_cfg(logic [7:0] mode_d, logic [7:0] r1, logic [7:0] r2,
                             logic [7:0] r3);
        write_reg(CFG_FOUR_BIT, mode_d);
        write_reg(CFG_ROW1, r1);
        write_reg(CFG_ROW2, r2);
        write_reg(CFG_ROW3, r3);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Block is quiet: queue drained, push low, every beat back. Ignored
    // requests leave no trace in strobe_q, so give the back end time too.
    task automatic wait_quiet();
        @(negedge i_clk);
        while (item_q.size() != 0 || push || strobe_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_random(int n);
        @(negedge i_clk);
        repeat (n) item_q.push_back(rand_req());
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps, and now and
    // then a full drain before the next request goes out.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit take;
        take = 1'b0;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_strobes(cur_req);
                sent_cnt++;
                if (sent_cnt == FORCED_DRAIN || $urandom_range(0, 39) == 0)
                    drain_hold = 1'b1;
            end
            // A request still waiting for acceptance holds the bus as it is.
            if (!push || !full) begin
                if (drain_hold && strobe_q.size() != 0) begin
                    take = 1'b0;
                end else begin
                    drain_hold = 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                    else if (item_q.size() != 0)
                        take = 1'b1;
                end
                if (take) begin
                    cur_req = item_q.pop_front();
                    i_req_type <= cur_req.req_type;
                    i_value    <= cur_req.value;
                    i_column   <= cur_req.column;
                    i_row      <= cur_req.row;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            3:       gap_left = $urandom_range(20, 80);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end
                end
                push <= take;
            end
        end
    end

    // ------------------------------------------------------------------
    // Strobe monitor and receiver: every accepted beat is checked against
    // the oldest expectation; pop follows its own mode pattern.
    // ------------------------------------------------------------------
    function automatic void report(string field, logic [7:0] want, logic [7:0] got);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    always @(posedge i_clk) begin
        t_lcd_strobe want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (strobe_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected beat, expected none, actual rs %0b data %0h last %0b",
                                 $time, o_reg_select, o_bus_data, o_last);
                end else begin
                    want = strobe_q.pop_front();
                    if (o_reg_select !== want.rs)
                        report("reg_select", 8'(want.rs), 8'(o_reg_select));
                    if (o_bus_data !== want.data)
                        report("bus_data", want.data, o_bus_data);
                    if (o_last !== want.last)
                        report("last", 8'(want.last), 8'(o_last));
                end
            end
            if (pop_left == 0) begin
                pop_mode = t_pop_mode'($urandom_range(0, 3));
                pop_left = $urandom_range(4, 64);
            end else begin
                pop_left--;
            end
            case (pop_mode)
                POP_ALWAYS: pop <= 1'b1;
                POP_HALF:   pop <= 1'($urandom_range(0, 1));
                POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                default:    pop <= 1'b0;
            endcase
        end
    end

    // Watchdog: cycles with no beat accepted on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no beat accepted for %0d cycles, %0d beats outstanding",
                 $time, WATCHDOG_LIMIT, strobe_q.size());
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at reset config (4-bit, standard row offsets).
        @(negedge i_clk);
        item_q.push_back(mk_req(REQ_CMD,   16'h0000, 8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_CMD,   16'hFFFF, 8'hFF, 8'hFF));
        item_q.push_back(mk_req(REQ_CMD,   16'h12A5, 8'h00, 8'h00)); // high bits ignored
        item_q.push_back(mk_req(REQ_CHAR,  16'h00FF, 8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_CHAR,  16'hFF00, 8'h00, 8'h00));
        // Numbers: leading-zero case, each digit-count boundary, oversized.
        item_q.push_back(mk_req(REQ_NUM,   16'd0,     8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_NUM,   16'd9,     8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_NUM,   16'd10,    8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_NUM,   16'd99,    8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_NUM,   16'd100,   8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_NUM,   16'd1000,  8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_NUM,   16'd9999,  8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_NUM,   16'd10000, 8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_NUM,   16'hFFFF,  8'h00, 8'h00));
        // Cursor moves on every row, rows past 3, address wrap.
        item_q.push_back(mk_req(REQ_MOVE,  16'h0000, 8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_MOVE,  16'h0000, 8'hFF, 8'h01));
        item_q.push_back(mk_req(REQ_MOVE,  16'h0000, 8'd100, 8'h02));
        item_q.push_back(mk_req(REQ_MOVE,  16'h0000, 8'd50, 8'h03));
        item_q.push_back(mk_req(REQ_MOVE,  16'hFFFF, 8'hFF, 8'hFF));
        // Line clears, including a row with no offset.
        item_q.push_back(mk_req(REQ_CLEAR, 16'h0000, 8'h00, 8'h00));
        item_q.push_back(mk_req(REQ_CLEAR, 16'h0000, 8'h00, 8'h01));
        item_q.push_back(mk_req(REQ_CLEAR, 16'h0000, 8'hFF, 8'h03));
        item_q.push_back(mk_req(REQ_CLEAR, 16'hFFFF, 8'h00, 8'd200));
        // Request types the block drops.
        item_q.push_back(mk_req(REQ_BAD_LO,        16'h1234, 8'h01, 8'h01));
        item_q.push_back(mk_req(REQ_BAD_LO + 3'd1, 16'h0005, 8'h00, 8'h02));
        item_q.push_back(mk_req(REQ_BAD_HI,        16'hFFFF, 8'hFF, 8'hFF));
        load_random(34);
        wait_quiet();

        // 8-bit mode, zero offsets; mode byte has every bit but bit 0 set.
        apply_cfg(8'hFE, 8'h00, 8'h00, 8'h00);
        load_random(40);
        wait_quiet();

        // 4-bit mode, maximum offsets: row addresses wrap for any nonzero column.
        apply_cfg(8'h01, 8'hFF, 8'hFF, 8'hFF);
        load_random(40);
        wait_quiet();

        // Random settings in each mode.
        apply_cfg({7'($urandom), 1'b0}, 8'($urandom), 8'($urandom), 8'($urandom));
        load_random(40);
        wait_quiet();

        apply_cfg({7'($urandom), 1'b1}, 8'($urandom), 8'($urandom), 8'($urandom));
        load_random(40);
        wait_quiet();

        if (strobe_q.size() != 0) begin
            fail_cnt++;
            $display("%0t: expected %0d more beats, actual 0", $time, strobe_q.size());
        end
        if (fail_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
